>>> rtl/core/usm_pkg.sv
package usm_pkg;

	localparam int PIX_W   = 8;
	localparam int ROWS_W  = 16;
	localparam int COLS_W  = 10;
	localparam int AMT_W   = 8;
	// rows*cols + cols + 1 stays below 2**26 for any register values
	localparam int ITEM_W  = 26;
	localparam int SUM_W   = 12;
	localparam int BLUR_W  = 25;

	localparam int Q_DEPTH = 4;
	localparam int Q_CNT_W = 3;

	localparam logic [12:0] BLUR_MUL = 13'd7282;
	localparam logic [15:0] BLUR_RND = 16'd32768;
	localparam logic [7:0]  PIX_MAX  = 8'd255;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef logic [8:0][PIX_W-1:0] win_t;

	typedef struct packed {
		logic top;
		logic bot;
		logic left;
		logic right;
		logic sof;
		logic eol;
	} border_t;

	typedef struct packed {
		win_t    win;
		border_t flags;
	} entry_t;

	typedef struct packed {
		logic [ROWS_W-1:0] rows_eff;
		logic [COLS_W-1:0] cols_eff;
		logic [AMT_W-1:0]  amount;
		logic [ITEM_W-1:0] n_in;
		logic [ITEM_W-1:0] total;
		logic [COLS_W:0]   lag;
	} cfg_t;

endpackage

>>> rtl/core/usm_ram.sv
module usm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/usm_fifo.sv
module usm_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr,
	input  usm_pkg::entry_t              wr_entry,
	input  logic                         rd,
	output usm_pkg::entry_t              rd_entry,
	output logic                         not_empty,
	output logic [usm_pkg::Q_CNT_W-1:0]  count
);

	localparam int PTR_W = $clog2(usm_pkg::Q_DEPTH);

	usm_pkg::entry_t  store_q [usm_pkg::Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [usm_pkg::Q_CNT_W-1:0] count_q;

	assign rd_entry  = store_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			store_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + usm_pkg::Q_CNT_W'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - usm_pkg::Q_CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/core/usm_front.sv
module usm_front #(
	parameter int LINE_DEPTH = 512
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  usm_pkg::cfg_t                cfg,
	input  logic                         push,
	output logic                         full,
	input  logic                         command,
	input  logic [usm_pkg::PIX_W-1:0]    in_pixel,
	output logic                         q_push,
	output usm_pkg::entry_t              q_entry,
	input  logic [usm_pkg::Q_CNT_W-1:0]  q_count
);

	localparam int ADDR_W = $clog2(LINE_DEPTH);
	localparam int PW     = usm_pkg::PIX_W;
	localparam int CW     = usm_pkg::COLS_W;
	localparam int RW     = usm_pkg::ROWS_W;
	localparam int IW     = usm_pkg::ITEM_W;

	logic          accept;
	logic [IW-1:0] items_q;
	logic [CW-1:0] in_col_q;
	logic [CW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;

	logic [CW-1:0] ix_c;
	logic [CW-1:0] ix_nxt;
	logic [CW-1:0] oc_c;
	logic [RW-1:0] orow_c;
	logic [IW:0]   i_nxt;
	logic          frame_end;
	logic          out_en;
	logic [PW-1:0] pix_c;
	usm_pkg::border_t flags_c;

	// stage 1: line buffer data is back
	logic              valid_s1;
	logic              out_en_s1;
	logic [PW-1:0]     pix_s1;
	logic [ADDR_W-1:0] ix_s1;
	usm_pkg::border_t  flags_s1;
	logic              byp_q;
	logic [2*PW-1:0]   byp_data_q;

	logic [2*PW-1:0]   ram_rd;
	logic [2*PW-1:0]   line_rd;
	logic [2*PW-1:0]   line_wr;
	logic [PW-1:0]     older_pix;
	logic [PW-1:0]     newer_pix;
	usm_pkg::win_t     win_q;
	usm_pkg::win_t     win_nxt;

	assign accept = push && !full;
	assign full   = ({1'b0, q_count} + {{usm_pkg::Q_CNT_W{1'b0}}, q_push})
	                >= (usm_pkg::Q_CNT_W + 1)'(usm_pkg::Q_DEPTH);

	always_comb begin
		ix_c   = (in_col_q >= cfg.cols_eff) ? '0 : in_col_q;
		ix_nxt = (({1'b0, ix_c} + (CW + 1)'(1)) >= {1'b0, cfg.cols_eff}) ? '0 :
		         ix_c + CW'(1);
		oc_c   = (out_col_q >= cfg.cols_eff) ? '0 : out_col_q;
		orow_c = (out_row_q >= cfg.rows_eff) ? cfg.rows_eff - RW'(1) : out_row_q;
		i_nxt     = {1'b0, items_q} + (IW + 1)'(1);
		frame_end = i_nxt >= {1'b0, cfg.total};
		out_en    = items_q >= IW'(cfg.lag);
		pix_c     = (command == usm_pkg::CMD_PIXEL && items_q < cfg.n_in) ? in_pixel : '0;

		flags_c.top   = (orow_c == '0);
		flags_c.bot   = ({1'b0, orow_c} + (RW + 1)'(1)) >= {1'b0, cfg.rows_eff};
		flags_c.left  = (oc_c == '0);
		flags_c.right = ({1'b0, oc_c} + (CW + 1)'(1)) >= {1'b0, cfg.cols_eff};
		flags_c.sof   = flags_c.top && flags_c.left;
		flags_c.eol   = flags_c.right;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_q   <= '0;
			in_col_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			valid_s1  <= 1'b0;
			byp_q     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				// read and write of one address at one edge: forward the write
				byp_q <= valid_s1 && (ix_s1 == ADDR_W'(ix_c));
				if (frame_end) begin
					items_q   <= '0;
					in_col_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else begin
					items_q  <= i_nxt[IW-1:0];
					in_col_q <= ix_nxt;
					if (out_en) begin
						if (flags_c.right) begin
							out_col_q <= '0;
							out_row_q <= flags_c.bot ? '0 : orow_c + RW'(1);
						end else begin
							out_col_q <= oc_c + CW'(1);
							out_row_q <= orow_c;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= pix_c;
			ix_s1      <= ADDR_W'(ix_c);
			out_en_s1  <= out_en;
			flags_s1   <= flags_c;
			byp_data_q <= line_wr;
		end
	end

	usm_ram #(
		.WIDTH (2 * PW),
		.DEPTH (LINE_DEPTH)
	) u_lines (
		.clk     (clk),
		.wr_en   (valid_s1),
		.wr_addr (ix_s1),
		.wr_data (line_wr),
		.rd_en   (accept),
		.rd_addr (ADDR_W'(ix_c)),
		.rd_data (ram_rd)
	);

	// word layout: older line high, newer line low
	assign line_rd   = byp_q ? byp_data_q : ram_rd;
	assign older_pix = line_rd[2*PW-1:PW];
	assign newer_pix = line_rd[PW-1:0];
	assign line_wr   = {newer_pix, pix_s1};

	always_comb begin
		win_nxt = win_q;
		for (int r = 0; r < 3; r++) begin
			win_nxt[r*3]   = win_q[r*3+1];
			win_nxt[r*3+1] = win_q[r*3+2];
		end
		win_nxt[2] = older_pix;
		win_nxt[5] = newer_pix;
		win_nxt[8] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (valid_s1) begin
			win_q <= win_nxt;
		end
	end

	assign q_push        = valid_s1 && out_en_s1;
	assign q_entry.win   = win_nxt;
	assign q_entry.flags = flags_s1;

endmodule

>>> rtl/core/usm_back.sv
module usm_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [usm_pkg::AMT_W-1:0] amount,
	input  usm_pkg::entry_t           q_entry,
	input  logic                      q_valid,
	output logic                      q_pop,
	output logic                      empty,
	input  logic                      pop,
	output logic [usm_pkg::PIX_W-1:0] out_pixel,
	output logic                      start_of_frame,
	output logic                      end_of_line
);

	localparam int PW = usm_pkg::PIX_W;
	localparam int SW = usm_pkg::SUM_W;
	localparam int BW = usm_pkg::BLUR_W;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [SW-1:0] sum_c;
	logic [SW-1:0] sum_s1;
	logic [PW-1:0] ctr_s1, ctr_s2, ctr_s3;
	logic [1:0]    fl_s1, fl_s2, fl_s3;

	logic [BW-1:0] blur_full;
	logic [PW-1:0] blur_s2;

	logic signed [PW:0]       diff_c;
	logic signed [2*PW+1:0]   prod_c;
	logic signed [2*PW+1:0]   prod_s3;

	logic signed [PW+2:0] sharp_c;
	logic [PW-1:0]        clamp_c;

	assign rdy_s4 = !v_s4 || pop;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign q_pop  = q_valid && rdy_s1;

	// box sum with border replication
	always_comb begin
		int rr;
		int cc;
		sum_c = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				rr = r;
				cc = c;
				if ((r == 0 && q_entry.flags.top) || (r == 2 && q_entry.flags.bot)) rr = 1;
				if ((c == 0 && q_entry.flags.left) || (c == 2 && q_entry.flags.right)) cc = 1;
				sum_c = sum_c + SW'(q_entry.win[rr*3+cc]);
			end
		end
	end

	assign blur_full = BW'(sum_s1) * BW'(usm_pkg::BLUR_MUL) + BW'(usm_pkg::BLUR_RND);

	assign diff_c = $signed({1'b0, ctr_s2}) - $signed({1'b0, blur_s2});
	assign prod_c = (2*PW+2)'(diff_c) * (2*PW+2)'($signed({1'b0, amount}));

	// arithmetic shift gives floor for negative products
	assign sharp_c = $signed({3'b000, ctr_s3}) + (PW+3)'(prod_s3 >>> 8);
	always_comb begin
		if (sharp_c < 0) begin
			clamp_c = '0;
		end else if (sharp_c > $signed({3'b000, usm_pkg::PIX_MAX})) begin
			clamp_c = usm_pkg::PIX_MAX;
		end else begin
			clamp_c = sharp_c[PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= q_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && q_valid) begin
			sum_s1 <= sum_c;
			ctr_s1 <= q_entry.win[4];
			fl_s1  <= {q_entry.flags.sof, q_entry.flags.eol};
		end
		if (rdy_s2 && v_s1) begin
			blur_s2 <= blur_full[16+PW-1:16];
			ctr_s2  <= ctr_s1;
			fl_s2   <= fl_s1;
		end
		if (rdy_s3 && v_s2) begin
			prod_s3 <= prod_c;
			ctr_s3  <= ctr_s2;
			fl_s3   <= fl_s2;
		end
		if (rdy_s4 && v_s3) begin
			out_pixel      <= clamp_c;
			start_of_frame <= fl_s3[1];
			end_of_line    <= fl_s3[0];
		end
	end

	assign empty = !v_s4;

endmodule

>>> rtl/core/unsharp_mask_3x3_box_top.sv
// Unsharp mask with a 3x3 box blur over an 8-bit gray raster stream.
// Input channel (push/full): one word per pixel in raster order, command
//   = pixel; after the frame's rows*cols pixels the host sends cols+1
//   drain words (command = drain, value ignored) to flush the last results.
// Result channel (empty/pop): one sharpened pixel per word with
//   start_of_frame on the first pixel and end_of_line on each row's last.
//   The first cols+1 words of a frame give no result; after that each
//   word gives exactly one, delayed by cols+1 words.
// Config: APB, registers frame_rows (0x0), frame_cols (0x4),
//   sharpen_amount (0x8); write only while the stream is idle.
// Path: a result that a word causes is registered in front stage 1,
//   written to the window queue, then passed through back stages s1 to s4,
//   the last of which is the output register.
// Throughput: one word per cycle unless full; the front is bound by the
//   single write port of the line buffer RAM, the back is a 4-stage pipe.
// Reset: counters, window and queues clear at once; line buffers are not
//   cleared, their stale entries only feed replicated border taps.
// Stall: when pop stays low the back pipe and the 4-entry queue fill
//   and full rises; nothing is lost or reordered.
module unsharp_mask_3x3_box_top #(
	parameter int LINE_DEPTH = 512
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [3:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      push,
	output logic                      full,
	input  logic                      command,
	input  logic [usm_pkg::PIX_W-1:0] in_pixel,
	output logic                      empty,
	input  logic                      pop,
	output logic [usm_pkg::PIX_W-1:0] out_pixel,
	output logic                      start_of_frame,
	output logic                      end_of_line
);

	localparam int RW = usm_pkg::ROWS_W;
	localparam int CW = usm_pkg::COLS_W;
	localparam int AW = usm_pkg::AMT_W;
	localparam int IW = usm_pkg::ITEM_W;

	localparam logic [1:0] REG_ROWS   = 2'd0;
	localparam logic [1:0] REG_COLS   = 2'd1;
	localparam logic [1:0] REG_AMOUNT = 2'd2;

	localparam int ROWS_RST = 480;
	localparam int COLS_RST = (512 > LINE_DEPTH) ? LINE_DEPTH : 512;

	logic          cfg_wr;
	logic [1:0]    reg_idx;
	logic [RW-1:0] rows_q, rows_nxt, rows_eff_nxt;
	logic [CW-1:0] cols_q, cols_nxt, cols_eff_nxt;
	logic [AW-1:0] amount_q, amount_nxt;
	logic [IW-1:0] n_in_nxt;
	usm_pkg::cfg_t cfg_q;

	usm_pkg::entry_t q_wr_entry;
	usm_pkg::entry_t q_rd_entry;
	logic            q_push;
	logic            q_pop;
	logic            q_valid;
	logic [usm_pkg::Q_CNT_W-1:0] q_count;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	always_comb begin
		rows_nxt   = (cfg_wr && reg_idx == REG_ROWS) ? pwdata[RW-1:0] : rows_q;
		cols_nxt   = (cfg_wr && reg_idx == REG_COLS) ? pwdata[CW-1:0] : cols_q;
		amount_nxt = (cfg_wr && reg_idx == REG_AMOUNT) ? pwdata[AW-1:0] : amount_q;
		// zero rows acts as one; columns clamp to 1..LINE_DEPTH
		rows_eff_nxt = (rows_nxt == '0) ? RW'(1) : rows_nxt;
		if (cols_nxt == '0) begin
			cols_eff_nxt = CW'(1);
		end else if (32'(cols_nxt) > LINE_DEPTH) begin
			cols_eff_nxt = CW'(LINE_DEPTH);
		end else begin
			cols_eff_nxt = cols_nxt;
		end
		n_in_nxt = IW'(rows_eff_nxt) * IW'(cols_eff_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q         <= RW'(ROWS_RST);
			cols_q         <= CW'(512);
			amount_q       <= '0;
			cfg_q.rows_eff <= RW'(ROWS_RST);
			cfg_q.cols_eff <= CW'(COLS_RST);
			cfg_q.amount   <= '0;
			cfg_q.n_in     <= IW'(ROWS_RST * COLS_RST);
			cfg_q.total    <= IW'(ROWS_RST * COLS_RST + COLS_RST + 1);
			cfg_q.lag      <= (CW + 1)'(COLS_RST + 1);
		end else begin
			rows_q         <= rows_nxt;
			cols_q         <= cols_nxt;
			amount_q       <= amount_nxt;
			cfg_q.rows_eff <= rows_eff_nxt;
			cfg_q.cols_eff <= cols_eff_nxt;
			cfg_q.amount   <= amount_nxt;
			cfg_q.n_in     <= n_in_nxt;
			cfg_q.total    <= n_in_nxt + IW'(cols_eff_nxt) + IW'(1);
			cfg_q.lag      <= {1'b0, cols_eff_nxt} + (CW + 1)'(1);
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ROWS:   prdata = 32'(rows_q);
			REG_COLS:   prdata = 32'(cols_q);
			REG_AMOUNT: prdata = 32'(amount_q);
			default:    prdata = '0;
		endcase
	end

	// front: counters, line buffers, window, border flags
	usm_front #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.full     (full),
		.command  (command),
		.in_pixel (in_pixel),
		.q_push   (q_push),
		.q_entry  (q_wr_entry),
		.q_count  (q_count)
	);

	// window queue between front and back
	usm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (q_push),
		.wr_entry  (q_wr_entry),
		.rd        (q_pop),
		.rd_entry  (q_rd_entry),
		.not_empty (q_valid),
		.count     (q_count)
	);

	// back: blur, sharpen, clamp, output register
	usm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.amount         (cfg_q.amount),
		.q_entry        (q_rd_entry),
		.q_valid        (q_valid),
		.q_pop          (q_pop),
		.empty          (empty),
		.pop            (pop),
		.out_pixel      (out_pixel),
		.start_of_frame (start_of_frame),
		.end_of_line    (end_of_line)
	);

endmodule

>>> verif/usm_checker.sv
package usm_tb_regs_pkg;

	localparam logic [3:0] ADDR_FRAME_ROWS     = 4'h0;
	localparam logic [3:0] ADDR_FRAME_COLS     = 4'h4;
	localparam logic [3:0] ADDR_SHARPEN_AMOUNT = 4'h8;

endpackage

module usm_checker
	import usm_pkg::*;
	import usm_tb_regs_pkg::*;
#(
	parameter int LINE_DEPTH = 512
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	input  logic [31:0]      prdata,
	input  logic             pready,
	input  logic             push,
	input  logic             full,
	input  logic             command,
	input  logic [PIX_W-1:0] in_pixel,
	input  logic             empty,
	input  logic             pop,
	input  logic [PIX_W-1:0] out_pixel,
	input  logic             start_of_frame,
	input  logic             end_of_line,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             sof;
		logic             eol;
	} sharpened_t;

	logic [ROWS_W-1:0] rows_reg = 16'd480;
	logic [COLS_W-1:0] cols_reg = 10'd512;
	logic [AMT_W-1:0]  amount_reg = '0;

	// line contents only reach results through unreplicated taps
	logic [PIX_W-1:0] older_row [LINE_DEPTH] = '{default: '0};
	logic [PIX_W-1:0] newer_row [LINE_DEPTH] = '{default: '0};
	logic [PIX_W-1:0] win [9] = '{default: '0};

	int unsigned items_seen;
	int unsigned in_col;
	int unsigned out_col;
	int unsigned out_row;

	sharpened_t sharpened_q [$];
	sharpened_t oldest;

	task automatic report_mismatch(input string what, input int got, input int wanted);
		fail_count++;
		$display("%0t usm_checker: %s got %0d expected %0d", $time, what, got, wanted);
	endtask

	function automatic logic [PIX_W-1:0] sharpen_value(input int center, input int blur,
			input int amount);
		int adj;
		int v;
		adj = ((center - blur) * amount) >>> 8;	// floor of a signed Q8 product
		v = center + adj;
		if (v < 0)
			v = 0;
		else if (v > int'(PIX_MAX))
			v = int'(PIX_MAX);
		return v[PIX_W-1:0];
	endfunction

	function automatic int unsigned readback_value(input logic [3:0] addr);
		case (addr)
			ADDR_FRAME_ROWS:     return rows_reg;
			ADDR_FRAME_COLS:     return cols_reg;
			ADDR_SHARPEN_AMOUNT: return amount_reg;
			default:             return 0;
		endcase
	endfunction

	// one accepted input word: shift line buffers and window, maybe emit a pixel
	task automatic sharpen_step(input logic cmd, input logic [PIX_W-1:0] pix);
		int unsigned rows_eff;
		int unsigned cols_eff;
		int unsigned n_pix;
		int unsigned lag;
		int unsigned idx;
		int unsigned sum;
		int unsigned blur;
		int rr;
		int cc;
		logic [PIX_W-1:0] fed;
		logic [PIX_W-1:0] tap_old;
		logic [PIX_W-1:0] tap_new;
		sharpened_t res;

		rows_eff = (rows_reg == 0) ? 1 : rows_reg;
		cols_eff = (cols_reg == 0) ? 1 : (cols_reg > LINE_DEPTH) ? LINE_DEPTH : cols_reg;
		n_pix = rows_eff * cols_eff;
		lag = cols_eff + 1;

		// zero goes in for drain ticks and for anything past the pixel phase
		fed = (cmd == CMD_PIXEL && items_seen < n_pix) ? pix : '0;

		if (in_col >= cols_eff)
			in_col = 0;
		idx = in_col;
		tap_old = older_row[idx];
		tap_new = newer_row[idx];
		older_row[idx] = tap_new;
		newer_row[idx] = fed;
		for (int r = 0; r < 3; r++) begin
			win[r*3] = win[r*3+1];
			win[r*3+1] = win[r*3+2];
		end
		win[2] = tap_old;
		win[5] = tap_new;
		win[8] = fed;

		if (items_seen >= lag) begin
			if (out_col >= cols_eff)
				out_col = 0;
			if (out_row >= rows_eff)
				out_row = rows_eff - 1;
			sum = 0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					rr = r;
					cc = c;
					if (out_row == 0 && r == 0)
						rr = 1;
					if (out_row + 1 >= rows_eff && r == 2)
						rr = 1;
					if (out_col == 0 && c == 0)
						cc = 1;
					if (out_col + 1 >= cols_eff && c == 2)
						cc = 1;
					sum += win[rr*3+cc];
				end
			end
			blur = ((sum * BLUR_MUL + BLUR_RND) >> 16) & PIX_MAX;
			res.pixel = sharpen_value(win[4], blur, amount_reg);
			res.sof = (out_row == 0 && out_col == 0);
			res.eol = (out_col + 1 >= cols_eff);
			sharpened_q.push_back(res);
			if (out_col + 1 >= cols_eff) begin
				out_col = 0;
				out_row = (out_row + 1 >= rows_eff) ? 0 : out_row + 1;
			end else begin
				out_col++;
			end
		end

		in_col = (idx + 1 >= cols_eff) ? 0 : idx + 1;

		if (items_seen + 1 >= n_pix + lag) begin
			items_seen = 0;
			in_col = 0;
			out_col = 0;
			out_row = 0;
		end else begin
			items_seen++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg = 16'd480;
			cols_reg = 10'd512;
			amount_reg = '0;
			win = '{default: '0};
			items_seen = 0;
			in_col = 0;
			out_col = 0;
			out_row = 0;
			sharpened_q.delete();
			pending = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr)
						ADDR_FRAME_ROWS:     rows_reg = pwdata[ROWS_W-1:0];
						ADDR_FRAME_COLS:     cols_reg = pwdata[COLS_W-1:0];
						ADDR_SHARPEN_AMOUNT: amount_reg = pwdata[AMT_W-1:0];
						default: ;
					endcase
				end else if (prdata != readback_value(paddr)) begin
					report_mismatch("register readback", prdata, readback_value(paddr));
				end
			end

			if (pop && !empty) begin
				if (sharpened_q.size() == 0) begin
					report_mismatch("word with nothing expected, out_pixel", out_pixel, -1);
				end else begin
					oldest = sharpened_q.pop_front();
					if (out_pixel != oldest.pixel)
						report_mismatch("out_pixel", out_pixel, oldest.pixel);
					if (start_of_frame != oldest.sof)
						report_mismatch("start_of_frame", start_of_frame, oldest.sof);
					if (end_of_line != oldest.eol)
						report_mismatch("end_of_line", end_of_line, oldest.eol);
				end
			end

			if (push && !full)
				sharpen_step(command, in_pixel);

			pending = sharpened_q.size();
		end
	end

endmodule

>>> verif/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import usm_pkg::*;
	import usm_tb_regs_pkg::*;

	localparam int HOLD_CYCLES    = 300;	// long receiver hold-off, fills the block
	localparam int SETTLE_CYCLES  = 16;	// lets the pipe clear of words with no result
	localparam int WATCHDOG_LIMIT = 3000;	// cycles with no handshake of any kind
	localparam int NOISE_PCT      = 4;	// words sent with the wrong command for the phase
	localparam int WORDS_PER_MODE = 60;
	localparam int unsigned FULL_FRAME = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		SLOW_READER,	// sender idles 14%, receiver 79%
		SLOW_WRITER,	// sender idles 79%, receiver 14%
		NO_IDLE
	} idle_mode_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [3:0]       paddr = '0;
	logic [31:0]      pwdata = '0;
	logic [31:0]      prdata;
	logic             pready;
	logic             push = 1'b0;
	logic             full;
	logic             command = CMD_PIXEL;
	logic [PIX_W-1:0] in_pixel = '0;
	logic             empty;
	logic             pop = 1'b0;
	logic [PIX_W-1:0] out_pixel;
	logic             start_of_frame;
	logic             end_of_line;

	int fail_count;
	int pending;

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	logic        hold_req = 1'b0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	int unsigned words_sent = 0;

	// effective frame shape, only used to size the word stream
	int unsigned cur_rows;
	int unsigned cur_cols;

	unsharp_mask_3x3_box_top #(.LINE_DEPTH(512)) dut (.*);

	usm_checker #(.LINE_DEPTH(512)) sharpen_check (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver: random pop, except during a requested hold-off where pop
	// stays low long enough for the back pipe and queue to fill and full to rise.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_req)
				hold_left <= HOLD_CYCLES;
			else if (hold_left != 0)
				hold_left <= hold_left - 1;
			pop <= !hold_req && hold_left == 0 && $urandom_range(99) >= recv_idle_pct;
		end
	end

	// Watchdog: any word on either channel or any config access counts as progress.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic set_idling(input idle_mode_t m);
		case (m)
			SLOW_READER: begin
				send_idle_pct <= 14;
				recv_idle_pct <= 79;
			end
			SLOW_WRITER: begin
				send_idle_pct <= 79;
				recv_idle_pct <= 14;
			end
			default: begin
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
			end
		endcase
	endtask

	// Offer one word; returns right after the edge that took it.
	// full is looked at on the falling edge so the decision is race free.
	task automatic send_word(input logic cmd, input logic [PIX_W-1:0] pix);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push     <= 1'b1;
		command  <= cmd;
		in_pixel <= pix;
		do @(negedge clk); while (full);
		@(posedge clk);
		words_sent++;
	endtask

	// Setup then access phase; psel drops before the task returns so back-to-back calls
	// never raise and drop psel in the same step.
	task automatic apb_access(input logic wr, input logic [3:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Registers only change with the block idle: wait for every expected
	// word, then let drain/lead-in words that make no result clear the pipe.
	task automatic set_config(input int unsigned rows, input int unsigned cols,
			input int unsigned amount);
		push <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_access(1'b1, ADDR_FRAME_ROWS, rows);
		apb_access(1'b1, ADDR_FRAME_COLS, cols);
		apb_access(1'b1, ADDR_SHARPEN_AMOUNT, amount);
		apb_access(1'b0, ADDR_FRAME_ROWS, '0);
		apb_access(1'b0, ADDR_FRAME_COLS, '0);
		apb_access(1'b0, ADDR_SHARPEN_AMOUNT, '0);
		cur_rows = (rows[ROWS_W-1:0] == 0) ? 1 : rows[ROWS_W-1:0];
		cur_cols = (cols[COLS_W-1:0] == 0) ? 1 :
			(cols[COLS_W-1:0] > 512) ? 512 : cols[COLS_W-1:0];
	endtask

	// A frame is rows*cols pixel words then cols+1 drain words. A few words
	// carry the wrong command for their phase; those feed zero into the window.
	task automatic stream_frame(input int unsigned max_words);
		int unsigned n_pix;
		int unsigned total;
		logic cmd;
		logic [PIX_W-1:0] pix;

		n_pix = cur_rows * cur_cols;
		total = n_pix + cur_cols + 1;
		if (max_words < total)
			total = max_words;
		for (int unsigned k = 0; k < total; k++) begin
			case ($urandom_range(9))
				0: pix = '0;
				1: pix = PIX_MAX;
				default: pix = $urandom_range(255);
			endcase
			cmd = (k < n_pix) ? CMD_PIXEL : CMD_DRAIN;
			if ($urandom_range(99) < NOISE_PCT)
				cmd = (cmd == CMD_PIXEL) ? CMD_DRAIN : CMD_PIXEL;
			send_word(cmd, pix);
		end
	endtask

	initial begin
		idle_mode_t  mode_list [3];
		int unsigned mode_start;
		int unsigned cols;
		int unsigned amount;

		mode_list = '{SLOW_READER, SLOW_WRITER, NO_IDLE};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// 3x3 checkerboard at full gain: drives both clamps, and a pixel
		// word in the drain phase whose value must be ignored
		set_config(3, 3, PIX_MAX);
		for (int k = 0; k < 9; k++)
			send_word(CMD_PIXEL, (k % 2 == 0) ? PIX_MAX : 8'h00);
		send_word(CMD_DRAIN, 8'h5A);
		send_word(CMD_PIXEL, PIX_MAX);
		send_word(CMD_DRAIN, 8'h00);
		send_word(CMD_DRAIN, PIX_MAX);

		// zero rows and zero cols both act as one; second frame opens with
		// a drain tick in the pixel phase
		set_config(0, 0, 128);
		send_word(CMD_PIXEL, 8'd200);
		send_word(CMD_DRAIN, 8'h00);
		send_word(CMD_DRAIN, 8'h00);
		send_word(CMD_DRAIN, 8'd77);
		send_word(CMD_DRAIN, 8'h00);
		send_word(CMD_DRAIN, 8'h00);

		// zero gain passes the center through
		set_config(2, 2, 0);
		send_word(CMD_PIXEL, 8'h01);
		send_word(CMD_PIXEL, 8'h80);
		send_word(CMD_PIXEL, 8'hFE);
		send_word(CMD_PIXEL, 8'h7F);
		send_word(CMD_DRAIN, 8'h00);
		send_word(CMD_DRAIN, 8'h00);
		send_word(CMD_DRAIN, 8'h00);

		// random frames, small shapes, under each idling pattern in turn
		foreach (mode_list[m]) begin
			mode_start = words_sent;
			if (mode_list[m] == SLOW_READER) begin
				// receiver holds off while the sender keeps pushing
				set_config(6, 10, $urandom_range(255));
				set_idling(mode_list[m]);
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
				stream_frame(FULL_FRAME);
			end
			while (words_sent - mode_start < WORDS_PER_MODE) begin
				cols = ($urandom_range(4) == 0) ? $urandom_range(1) : $urandom_range(2, 12);
				amount = ($urandom_range(3) == 0) ? PIX_MAX * $urandom_range(1) :
					$urandom_range(255);
				set_config($urandom_range(5), cols, amount);
				set_idling(mode_list[m]);
				repeat ($urandom_range(1, 3)) stream_frame(FULL_FRAME);
			end
		end

		// tallest frame with an out-of-range column count; only its head is
		// sent, enough to see the whole first row at the widest line
		set_config(16'hFFFF, 10'h3FF, PIX_MAX);
		set_idling(NO_IDLE);
		stream_frame(1025);

		push <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
